>>> sv/sbkc_pkg.sv
`default_nettype none

package sbkc_pkg;

    // action codes carried in the input tuser
    localparam logic [1:0] ACT_DRAW  = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_MARKER = 2'd0;
    localparam logic [1:0] CFG_BLANK  = 2'd1;
    localparam logic [1:0] CFG_IGNORE = 2'd2;

    // register reset values
    localparam logic [7:0] RESET_MARKER = 8'd43;
    localparam logic [7:0] RESET_BLANK  = 8'd32;
    localparam logic [7:0] RESET_IGNORE = 8'd45;

    // widest frame address for the largest supported buffer
    localparam int MEM_ADDR_W = 16;

    typedef struct packed {
        logic                  rd_en;
        logic [MEM_ADDR_W-1:0] rd_addr;
        logic                  wr_attr_en;
        logic                  wr_char_en;
        logic [MEM_ADDR_W-1:0] wr_addr;
        logic [15:0]           wr_attr;
        logic [15:0]           wr_char;
    } t_mem_req;

endpackage

`default_nettype wire

>>> sv/sbkc_store.sv
`default_nettype none

module sbkc_store #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13
) (
    input  wire                logic i_clk,
    input  wire sbkc_pkg::t_mem_req  i_req,
    output logic [15:0]              o_rd_attr,
    output logic [15:0]              o_rd_char
);
    import sbkc_pkg::*;

    // attributes and characters in separate arrays so clear touches only characters
    logic [15:0] r_mem_attr [DEPTH];
    logic [15:0] r_mem_char [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.wr_attr_en) begin
            r_mem_attr[i_req.wr_addr[ADDR_W-1:0]] <= i_req.wr_attr;
        end
        if (i_req.wr_char_en) begin
            r_mem_char[i_req.wr_addr[ADDR_W-1:0]] <= i_req.wr_char;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            o_rd_attr <= r_mem_attr[i_req.rd_addr[ADDR_W-1:0]];
            o_rd_char <= r_mem_char[i_req.rd_addr[ADDR_W-1:0]];
        end
    end

endmodule

`default_nettype wire

>>> sv/sbkc_locate.sv
`default_nettype none

module sbkc_locate #(
    parameter int BUF_WIDTH        = 128,
    parameter int BUF_HEIGHT       = 64,
    parameter int MAX_SPRITE_WIDTH = 64,
    parameter int CC_W             = 6,
    parameter int ADDR_W           = 13
) (
    input  wire logic              i_draw,
    input  wire logic signed [8:0] i_pos_x,
    input  wire logic signed [8:0] i_pos_y,
    input  wire logic [6:0]        i_sprite_width,
    input  wire logic              i_flipped,
    input  wire logic [CC_W-1:0]   i_col_count,
    input  wire logic [8:0]        i_row_count,
    output logic                   o_on_screen,
    output logic [ADDR_W-1:0]      o_addr,
    output logic [CC_W-1:0]        o_col_next,
    output logic [8:0]             o_row_next
);

    logic [9:0]         w_width;
    logic [9:0]         w_cc;
    logic [9:0]         w_cc_inc;
    logic [9:0]         w_offset;
    logic signed [10:0] w_col;
    logic signed [10:0] w_row;
    logic [19:0]        w_lin;

    always_comb begin
        // width zero acts as one, oversize saturates
        if (i_sprite_width == 7'd0) begin
            w_width = 10'd1;
        end else if (32'(i_sprite_width) > MAX_SPRITE_WIDTH) begin
            w_width = 10'(MAX_SPRITE_WIDTH);
        end else begin
            w_width = 10'(i_sprite_width);
        end

        w_cc = (10'(i_col_count) >= w_width) ? (w_width - 10'd1) : 10'(i_col_count);

        if (!i_draw) begin
            w_offset = 10'd0;
        end else if (i_flipped) begin
            w_offset = w_width - 10'd1 - w_cc;
        end else begin
            w_offset = w_cc;
        end

        w_col = 11'(i_pos_x) + $signed({1'b0, w_offset});
        w_row = 11'(i_pos_y) + $signed({2'b00, (i_draw ? i_row_count : 9'd0)});

        o_on_screen = !w_col[10] && (w_col[9:0] < 10'(BUF_WIDTH))
                   && !w_row[10] && (w_row[9:0] < 10'(BUF_HEIGHT));

        w_lin  = 20'(w_row[9:0]) * 20'(BUF_WIDTH) + 20'(w_col[9:0]);
        o_addr = w_lin[ADDR_W-1:0];

        w_cc_inc = w_cc + 10'd1;
        if (w_cc_inc >= w_width) begin
            o_col_next = '0;
            o_row_next = i_row_count + 9'd1;
        end else begin
            o_col_next = w_cc_inc[CC_W-1:0];
            o_row_next = i_row_count;
        end
    end

endmodule

`default_nettype wire

>>> sv/sprite_blit_key_clip_collide.sv
// draw and read items: the frame memory read is registered in the store, then the execute step does any
// write-back and loads any result into the output register; no new item is taken until it ends
// a final cell or a read holds its execute step while an earlier result waits downstream
// clear item: accepted, then a sweep over every address writes blank characters, attributes kept
// reset: synchronous active-low; afterwards a pass over all BUF_WIDTH*BUF_HEIGHT addresses
// (8192 at default size) writes blank characters and zero attributes, no items taken
// configuration writes are taken every cycle, including during sweeps
`default_nettype none

module sprite_blit_key_clip_collide #(
    parameter int BUF_WIDTH        = 128,
    parameter int BUF_HEIGHT       = 64,
    parameter int MAX_SPRITE_WIDTH = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    // input items
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // pos_x[8:0], pos_y[17:9], sprite_width[24:18], flipped[25], test_hit[26],
    // key_attr[42:27], key_char[58:43], collision_char[66:59], cell_attr[82:67],
    // cell_char[98:83], zero fill[103:99]
    input  wire logic [103:0] i_s_tdata,
    // action[1:0]
    input  wire logic [1:0]   i_s_tuser,
    // last_cell
    input  wire logic         i_s_tlast,

    // result items
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // self_overlap[0], other_overlap[1], read_attr[17:2], read_char[33:18], zero fill[39:34]
    output logic [39:0]       o_m_tdata,

    // configuration writes
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data
);
    import sbkc_pkg::*;

    localparam int DEPTH  = BUF_WIDTH * BUF_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CC_W   = (MAX_SPRITE_WIDTH > 1) ? $clog2(MAX_SPRITE_WIDTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    // controller states
    localparam logic [1:0] ST_INIT  = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;
    localparam logic [1:0] ST_CLEAR = 2'd3;

    // input field views
    logic signed [8:0] w_pos_x;
    logic signed [8:0] w_pos_y;
    logic [6:0]        w_sprite_width;
    logic              w_flipped;
    logic              w_test_hit;
    logic [15:0]       w_key_attr;
    logic [15:0]       w_key_char;
    logic [7:0]        w_collision_char;
    logic [15:0]       w_cell_attr;
    logic [15:0]       w_cell_char;
    logic              w_in_acc;

    assign w_pos_x          = $signed(i_s_tdata[8:0]);
    assign w_pos_y          = $signed(i_s_tdata[17:9]);
    assign w_sprite_width   = i_s_tdata[24:18];
    assign w_flipped        = i_s_tdata[25];
    assign w_test_hit       = i_s_tdata[26];
    assign w_key_attr       = i_s_tdata[42:27];
    assign w_key_char       = i_s_tdata[58:43];
    assign w_collision_char = i_s_tdata[66:59];
    assign w_cell_attr      = i_s_tdata[82:67];
    assign w_cell_char      = i_s_tdata[98:83];

    // control state
    logic [1:0]        r_state, n_state;
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic [CC_W-1:0]   r_cc, n_cc;
    logic [8:0]        r_row, n_row;
    logic              r_self, n_self;
    logic              r_other, n_other;
    logic              r_out_valid, n_out_valid;
    logic [7:0]        r_marker;
    logic [7:0]        r_blank;
    logic [7:0]        r_ignore;

    // item held while the memory read completes
    logic [1:0]        r_act;
    logic              r_on;
    logic [ADDR_W-1:0] r_addr;
    logic              r_unkeyed;
    logic              r_test;
    logic [7:0]        r_coll;
    logic [15:0]       r_cell_attr;
    logic [15:0]       r_cell_char;
    logic              r_last;
    logic [CC_W-1:0]   r_cc_next;
    logic [8:0]        r_row_next;
    logic [39:0]       r_out_data;

    // position unit outputs
    logic              w_loc_on;
    logic [ADDR_W-1:0] w_loc_addr;
    logic [CC_W-1:0]   w_loc_cc_next;
    logic [8:0]        w_loc_row_next;

    t_mem_req          w_req;
    logic [15:0]       w_rd_attr;
    logic [15:0]       w_rd_char;

    logic              w_out_free;
    logic              w_out_load;
    logic [39:0]       w_out_data;
    logic              w_hit_self;
    logic              w_hit_other;
    logic [7:0]        w_cur;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = r_out_data;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;

    sbkc_locate #(
        .BUF_WIDTH        (BUF_WIDTH),
        .BUF_HEIGHT       (BUF_HEIGHT),
        .MAX_SPRITE_WIDTH (MAX_SPRITE_WIDTH),
        .CC_W             (CC_W),
        .ADDR_W           (ADDR_W)
    ) u_locate (
        .i_draw         (i_s_tuser == ACT_DRAW),
        .i_pos_x        (w_pos_x),
        .i_pos_y        (w_pos_y),
        .i_sprite_width (w_sprite_width),
        .i_flipped      (w_flipped),
        .i_col_count    (r_cc),
        .i_row_count    (r_row),
        .o_on_screen    (w_loc_on),
        .o_addr         (w_loc_addr),
        .o_col_next     (w_loc_cc_next),
        .o_row_next     (w_loc_row_next)
    );

    sbkc_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_req     (w_req),
        .o_rd_attr (w_rd_attr),
        .o_rd_char (w_rd_char)
    );

    // collision test on the low character bytes of the stored and the new cell
    always_comb begin
        w_cur       = w_rd_char[7:0];
        w_hit_self  = 1'b0;
        w_hit_other = 1'b0;
        if (r_unkeyed && r_on && r_test && (w_cur != r_blank) && (w_cur != r_ignore)) begin
            if (w_cur == r_marker) begin
                w_hit_self = (r_cell_char[7:0] != r_blank) && (r_cell_char[7:0] != r_ignore)
                          && (r_cell_char[7:0] != r_coll);
            end else begin
                w_hit_other = (r_cell_char[7:0] == r_coll);
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_cc        = r_cc;
        n_row       = r_row;
        n_self      = r_self;
        n_other     = r_other;
        w_req       = '0;
        w_out_load  = 1'b0;
        w_out_data  = '0;

        unique case (r_state)
            ST_INIT: begin
                // power-up pass: blank characters, zero attributes
                w_req.wr_attr_en = 1'b1;
                w_req.wr_char_en = 1'b1;
                w_req.wr_addr    = MEM_ADDR_W'(r_sweep);
                w_req.wr_attr    = '0;
                w_req.wr_char    = 16'(RESET_BLANK);
                if (r_sweep == LAST_ADDR) begin
                    n_state = ST_IDLE;
                    n_sweep = '0;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_s_tuser) inside
                        ACT_DRAW, ACT_READ: begin
                            w_req.rd_en   = 1'b1;
                            w_req.rd_addr = MEM_ADDR_W'(w_loc_addr);
                            n_state       = ST_EXEC;
                        end
                        ACT_CLEAR: begin
                            n_state = ST_CLEAR;
                            n_sweep = '0;
                        end
                        ACT_NONE: begin
                        end
                    endcase
                end
            end
            ST_EXEC: begin
                if (r_act == ACT_DRAW) begin
                    // a final cell waits until the output register can take its result
                    if (!r_last || w_out_free) begin
                        if (r_unkeyed && r_on) begin
                            w_req.wr_attr_en = 1'b1;
                            w_req.wr_char_en = 1'b1;
                            w_req.wr_addr    = MEM_ADDR_W'(r_addr);
                            w_req.wr_attr    = r_cell_attr;
                            w_req.wr_char    = r_cell_char;
                        end
                        if (r_last) begin
                            w_out_load = 1'b1;
                            w_out_data = {38'd0, r_other | w_hit_other, r_self | w_hit_self};
                            n_cc       = '0;
                            n_row      = '0;
                            n_self     = 1'b0;
                            n_other    = 1'b0;
                        end else begin
                            n_cc    = r_cc_next;
                            n_row   = r_row_next;
                            n_self  = r_self | w_hit_self;
                            n_other = r_other | w_hit_other;
                        end
                        n_state = ST_IDLE;
                    end
                end else begin
                    // read result, zero when off screen
                    if (w_out_free) begin
                        w_out_load = 1'b1;
                        if (r_on) begin
                            w_out_data = {6'd0, w_rd_char, w_rd_attr, 2'b00};
                        end
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_CLEAR: begin
                // characters only, attributes kept
                w_req.wr_char_en = 1'b1;
                w_req.wr_addr    = MEM_ADDR_W'(r_sweep);
                w_req.wr_char    = 16'(r_blank);
                if (r_sweep == LAST_ADDR) begin
                    n_state = ST_IDLE;
                    n_sweep = '0;
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
        endcase

        if (w_out_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sweep     <= '0;
            r_cc        <= '0;
            r_row       <= '0;
            r_self      <= 1'b0;
            r_other     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_cc        <= n_cc;
            r_row       <= n_row;
            r_self      <= n_self;
            r_other     <= n_other;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_marker <= RESET_MARKER;
            r_blank  <= RESET_BLANK;
            r_ignore <= RESET_IGNORE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MARKER: r_marker <= i_cfg_data;
                CFG_BLANK:  r_blank  <= i_cfg_data;
                CFG_IGNORE: r_ignore <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_act       <= i_s_tuser;
            r_on        <= w_loc_on;
            r_addr      <= w_loc_addr;
            r_unkeyed   <= (w_cell_attr != w_key_attr) || (w_cell_char != w_key_char);
            r_test      <= w_test_hit;
            r_coll      <= w_collision_char;
            r_cell_attr <= w_cell_attr;
            r_cell_char <= w_cell_char;
            r_last      <= i_s_tlast;
            r_cc_next   <= w_loc_cc_next;
            r_row_next  <= w_loc_row_next;
        end
        if (w_out_load) begin
            r_out_data <= w_out_data;
        end
    end

    // a waiting result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !w_out_load)
        else $error("result register overwritten while stalled");

    // results come only from the execute step
    a_load_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (r_state == ST_EXEC))
        else $error("result produced outside execute step");

    // never read and write the frame memory in one cycle
    a_no_rd_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.rd_en |-> !(w_req.wr_attr_en || w_req.wr_char_en))
        else $error("frame memory read and written together");

    // flags and counters restart after a final cell
    a_flags_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_load && (r_act == ACT_DRAW)) |=>
            (!r_self && !r_other && (r_cc == '0) && (r_row == 9'd0)))
        else $error("draw progress not restarted after final cell");

    // reset always starts the clearing pass
    a_reset_init: assert property (@(posedge i_clk)
        !i_rst_n |=> ((r_state == ST_INIT) && (r_sweep == '0)))
        else $error("reset did not start the clearing pass");

endmodule

`default_nettype wire
